/* hdl/mpint_encoder_core_assert.svh */
// Assertion macros for the mpint encoder blocks.
// Expects clk and rst_n in the scope of each use.
`ifndef MPINT_ENCODER_CORE_ASSERT_SVH
`define MPINT_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MPE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MPE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define MPE_ASSERT(label, cond, msg)
`define MPE_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* hdl/mpe_pkg.sv */
// Shared types and constants for the mpint encoder.
// No dependencies.
package mpe_pkg;

  localparam logic [7:0] TOP_BIT  = 8'h80;
  localparam logic [1:0] HDR_LAST = 2'd3;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ERR,
    B_HDR,
    B_PAD,
    B_RD,
    B_WAIT
  } back_state_t;

endpackage

/* hdl/mpe_front.sv */
// Front end: drops leading zero bytes, writes significant bytes to the store,
// and queues one descriptor per integer. Uses mpe_pkg.
module mpe_front import mpe_pkg::*; #(
  parameter int MAX_BYTES = 32,
  localparam int CNT_W  = ($clog2(MAX_BYTES + 1) < 2) ? 2 : $clog2(MAX_BYTES + 1),
  localparam int IDX_W  = (MAX_BYTES < 2) ? 1 : $clog2(MAX_BYTES),
  localparam int ADDR_W = IDX_W + 1,
  localparam int DESC_W = CNT_W + 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              push,
  output logic              full,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              q_push,
  output logic [DESC_W-1:0] q_data,
  input  logic              q_full
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             seen_r, seen_nxt;
  logic             ovf_r, ovf_nxt;
  logic             pad_r, pad_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic             sig;

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign sig     = seen_r || (in_byte != 8'd0);
  assign wr_addr = {bank_r, count_r[IDX_W-1:0]};
  assign wr_data = in_byte;

  always_comb begin
    count_nxt = count_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    pad_nxt   = pad_r;
    bank_nxt  = bank_r;
    wr_en     = 1'b0;
    q_push    = 1'b0;
    q_data    = '0;
    if (accept) begin
      if (sig) begin
        seen_nxt = 1'b1;
        if (count_r < CNT_W'(MAX_BYTES)) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (count_r == '0) begin
            pad_nxt = (in_byte & TOP_BIT) != 8'd0;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      if (in_last) begin
        q_push    = 1'b1;
        q_data    = {ovf_nxt, pad_nxt, bank_r, count_nxt};
        count_nxt = '0;
        seen_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
        pad_nxt   = 1'b0;
        bank_nxt  = ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      pad_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      pad_r   <= pad_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

/* hdl/mpe_desc_q.sv */
// Two-entry descriptor queue between front and back ends.
// Uses the assertion macros header.
`include "mpint_encoder_core_assert.svh"
module mpe_desc_q #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_push,
  input  logic [W-1:0] q_data,
  output logic         q_full,
  input  logic         q_pop,
  output logic         q_empty,
  output logic [W-1:0] q_head
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = q_push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, q_push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wp_r] <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `MPE_ASSERT(a_push_room, !(q_push && q_full), "descriptor pushed into full queue")
  `MPE_ASSERT(a_pop_data, !(q_pop && q_empty), "descriptor popped from empty queue")
  `MPE_ASSERT(a_cnt_range, cnt_r != 2'd3, "descriptor count out of range")

endmodule

/* hdl/mpe_back.sv */
// Back end: holds the two-bank byte store and emits the length header, pad
// and stored bytes per descriptor, or one overflow byte. Uses mpe_pkg.
module mpe_back import mpe_pkg::*; #(
  parameter int MAX_BYTES = 32,
  localparam int CNT_W     = ($clog2(MAX_BYTES + 1) < 2) ? 2 : $clog2(MAX_BYTES + 1),
  localparam int IDX_W     = (MAX_BYTES < 2) ? 1 : $clog2(MAX_BYTES),
  localparam int ADDR_W    = IDX_W + 1,
  localparam int DESC_W    = CNT_W + 3,
  localparam int LEN_W     = CNT_W + 1,
  localparam int MEM_DEPTH = 2 ** ADDR_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              q_empty,
  input  logic [DESC_W-1:0] q_head,
  output logic              q_pop,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_overflow,
  output logic              empty,
  input  logic              pop
);

  logic [7:0]       mem_r [MEM_DEPTH];
  logic [7:0]       rdata_r;
  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r;
  logic             ol_r;
  logic             oo_r;

  logic [CNT_W-1:0]  d_count;
  logic              d_bank;
  logic              d_pad;
  logic              d_ovf;
  logic [LEN_W-1:0]  len;
  logic              slot;
  logic              load;
  logic [7:0]        lb;
  logic              ll;
  logic              lo;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              data_last;

  assign d_count   = q_head[CNT_W-1:0];
  assign d_bank    = q_head[CNT_W];
  assign d_pad     = q_head[CNT_W+1];
  assign d_ovf     = q_head[CNT_W+2];
  assign len       = LEN_W'(d_count) + LEN_W'(d_pad);
  assign rd_addr   = {d_bank, idx_r[IDX_W-1:0]};
  assign data_last = (LEN_W'(idx_r) + LEN_W'(1)) == LEN_W'(d_count);
  assign slot      = !ov_r || pop;

  assign out_byte     = ob_r;
  assign out_last     = ol_r;
  assign out_overflow = oo_r;
  assign empty        = !ov_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    load      = 1'b0;
    lb        = 8'd0;
    ll        = 1'b0;
    lo        = 1'b0;
    rd_en     = 1'b0;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          idx_nxt   = '0;
          state_nxt = d_ovf ? B_ERR : B_HDR;
        end
      end
      B_ERR: begin
        if (slot) begin
          load      = 1'b1;
          ll        = 1'b1;
          lo        = 1'b1;
          q_pop     = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_HDR: begin
        if (slot) begin
          load = 1'b1;
          if (idx_r == CNT_W'(HDR_LAST)) begin
            lb      = 8'(len);
            idx_nxt = '0;
            if (d_count == '0) begin
              ll        = 1'b1;
              q_pop     = 1'b1;
              state_nxt = B_IDLE;
            end else begin
              state_nxt = d_pad ? B_PAD : B_RD;
            end
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      B_PAD: begin
        if (slot) begin
          load      = 1'b1;
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        rd_en     = 1'b1;
        state_nxt = B_WAIT;
      end
      B_WAIT: begin
        if (slot) begin
          load = 1'b1;
          lb   = rdata_r;
          ll   = data_last;
          if (data_last) begin
            q_pop     = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = B_RD;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    ov_nxt = load ? 1'b1 : (pop ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= lb;
      ol_r <= ll;
      oo_r <= lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

/* hdl/mpint_encoder_core.sv */
// Top level of the SSH mpint encoder: front end, descriptor queue, back end.
// Depends on mpe_pkg, mpe_front, mpe_desc_q and mpe_back.
//
//   channel  ports                         accepted when
//   input    in_byte, in_last              push && !full
//   result   out_byte, out_last,           pop && !empty
//            out_overflow
//
// Input bytes are taken one per cycle while the descriptor queue has room;
// two integers may be held, one in each bank of the byte store.
// Header and pad bytes leave one per cycle while the result port is popped;
// each stored byte needs a registered store read, in states B_RD and B_WAIT.
// Reset is synchronous, active low; the store needs no clearing pass.
// A stalled result port holds the back end; the front end runs on until the
// queue fills.
module mpint_encoder_core #(
  parameter int MAX_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_overflow,
  output logic       empty,
  input  logic       pop
);

  localparam int CNT_W  = ($clog2(MAX_BYTES + 1) < 2) ? 2 : $clog2(MAX_BYTES + 1);
  localparam int IDX_W  = (MAX_BYTES < 2) ? 1 : $clog2(MAX_BYTES);
  localparam int ADDR_W = IDX_W + 1;
  localparam int DESC_W = CNT_W + 3;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              q_push;
  logic [DESC_W-1:0] q_data;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  logic [DESC_W-1:0] q_head;

  mpe_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .full    (full),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full)
  );

  mpe_desc_q #(.W(DESC_W)) u_desc_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  mpe_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_overflow (out_overflow),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
